[rtl/ssd_pkg.sv]
package ssd_pkg;

  localparam int unsigned PHASE_COUNT = 8;
  localparam int unsigned COIL_COUNT  = 4;
  localparam int unsigned PHASE_W     = $clog2(PHASE_COUNT);

  localparam int unsigned HELD_W   = 4;
  localparam int unsigned DELAY_W  = 16;
  localparam int unsigned TURN_W   = 12;
  localparam int unsigned BASE_W   = 10;
  localparam int unsigned DSTEP_W  = 8;

  localparam logic [HELD_W-1:0] HELD_MAX = '1;

  // Reset values of the configuration registers.
  localparam logic               WHEEL_SIDE_RST   = 1'b1;
  localparam logic [BASE_W-1:0]  BASE_DELAY_RST   = 10'd5;
  localparam logic [DSTEP_W-1:0] DELAY_STEP_RST   = 8'd4;
  localparam logic [DELAY_W-1:0] MAX_DELAY_RST    = 16'd1000;
  localparam logic [HELD_W-1:0]  HOLD_SECONDS_RST = 4'd2;
  localparam logic [TURN_W-1:0]  TURN_STEPS_RST   = 12'd256;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_TURN  = 2'd1,
    MODE_DRIVE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    TURN_NONE  = 2'd0,
    TURN_LEFT  = 2'd1,
    TURN_RIGHT = 2'd2
  } turn_e;

  typedef enum logic [2:0] {
    REG_WHEEL_SIDE   = 3'd0,
    REG_BASE_DELAY   = 3'd1,
    REG_DELAY_STEP   = 3'd2,
    REG_MAX_DELAY    = 3'd3,
    REG_HOLD_SECONDS = 3'd4,
    REG_TURN_STEPS   = 3'd5
  } reg_e;

  typedef struct packed {
    logic [DELAY_W-1:0]    delay_now;
    mode_e                 mode;
    logic                  step_strobe;
    logic [COIL_COUNT-1:0] coils;
  } result_t;

  // Half-step coil sequence.
  function automatic logic [COIL_COUNT-1:0] coil_pattern(input logic [PHASE_W-1:0] idx);
    logic [COIL_COUNT-1:0] pat;
    case (idx)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

  function automatic turn_e turn_kind(input logic [2:0] now, input logic [2:0] goal);
    turn_e k;
    k = TURN_NONE;
    if ((now == 3'd1 && goal == 3'd3) || (now == 3'd2 && goal == 3'd4) ||
        (now == 3'd3 && goal == 3'd2) || (now == 3'd4 && goal == 3'd1)) begin
      k = TURN_LEFT;
    end else if ((now == 3'd1 && goal == 3'd4) || (now == 3'd2 && goal == 3'd3) ||
                 (now == 3'd3 && goal == 3'd1) || (now == 3'd4 && goal == 3'd2)) begin
      k = TURN_RIGHT;
    end
    return k;
  endfunction

endpackage

[rtl/stepper_steering_drive_core.sv]
// Channel    Direction  Handshake                       Payload
// s_axis     in         s_axis_tvalid / s_axis_tready   tuser: command; tdata: tick fields
// m_axis     out        m_axis_tvalid / m_axis_tready   tdata: coils, strobe, mode, delay
// apb        in         psel, penable, pwrite, pready   six registers at byte address 4*i
//
// Each input transfer gives exactly one result transfer, held in the output register from
// the accepting edge on, at one item per cycle while m_axis keeps up.
// s_axis_tready is high while the output register is empty or drains in the same cycle;
// a stalled output holds its result and blocks only further input transfers.
// Reset (rst_ni low, asynchronous) returns the drive to idle with step delay 5 and coils
// off, and the configuration registers to their defaults.
module stepper_steering_drive_core
  import ssd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser,
  // [0] second_pulse, [1] left_flag, [2] right_flag, [5:3] goal_dir, [8:6] heading_now,
  // [15:9] zero
  input  logic [15:0] s_axis_tdata,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] coils, [4] step_strobe, [6:5] mode, [22:7] delay_now, [23] zero
  output logic [23:0] m_axis_tdata,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ------------------------------------------------------------------------
  // Configuration registers. Writes complete in the APB access phase.
  // ------------------------------------------------------------------------
  logic               wheel_side_q;
  logic [BASE_W-1:0]  base_delay_q;
  logic [DSTEP_W-1:0] delay_step_q;
  logic [DELAY_W-1:0] max_delay_q;
  logic [HELD_W-1:0]  hold_seconds_q;
  logic [TURN_W-1:0]  turn_steps_q;

  logic cfg_we;
  reg_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_side_q   <= WHEEL_SIDE_RST;
      base_delay_q   <= BASE_DELAY_RST;
      delay_step_q   <= DELAY_STEP_RST;
      max_delay_q    <= MAX_DELAY_RST;
      hold_seconds_q <= HOLD_SECONDS_RST;
      turn_steps_q   <= TURN_STEPS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_WHEEL_SIDE:   wheel_side_q   <= pwdata[0];
        REG_BASE_DELAY:   base_delay_q   <= pwdata[BASE_W-1:0];
        REG_DELAY_STEP:   delay_step_q   <= pwdata[DSTEP_W-1:0];
        REG_MAX_DELAY:    max_delay_q    <= pwdata[DELAY_W-1:0];
        REG_HOLD_SECONDS: hold_seconds_q <= pwdata[HELD_W-1:0];
        REG_TURN_STEPS:   turn_steps_q   <= pwdata[TURN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WHEEL_SIDE:   prdata = {31'd0, wheel_side_q};
      REG_BASE_DELAY:   prdata = {22'd0, base_delay_q};
      REG_DELAY_STEP:   prdata = {24'd0, delay_step_q};
      REG_MAX_DELAY:    prdata = {16'd0, max_delay_q};
      REG_HOLD_SECONDS: prdata = {28'd0, hold_seconds_q};
      REG_TURN_STEPS:   prdata = {20'd0, turn_steps_q};
      default:          prdata = 32'd0;
    endcase
  end

  // ------------------------------------------------------------------------
  // Input fields.
  // ------------------------------------------------------------------------
  logic       in_acc;
  cmd_e       cmd;
  logic       sec_pulse;
  logic       left_flag;
  logic       right_flag;
  logic [2:0] goal_dir;
  logic [2:0] heading_now;

  assign cmd         = cmd_e'(s_axis_tuser);
  assign sec_pulse   = s_axis_tdata[0];
  assign left_flag   = s_axis_tdata[1];
  assign right_flag  = s_axis_tdata[2];
  assign goal_dir    = s_axis_tdata[5:3];
  assign heading_now = s_axis_tdata[8:6];

  // ------------------------------------------------------------------------
  // Drive state.
  // ------------------------------------------------------------------------
  mode_e                 mode_q, mode_d;
  logic [PHASE_W-1:0]    phase_q, phase_d;
  logic                  backward_q, backward_d;
  logic [TURN_W-1:0]     turn_rem_q, turn_rem_d;
  logic [DELAY_W-1:0]    delay_q, delay_d;
  logic [DELAY_W-1:0]    wait_q, wait_d;
  logic                  lseen_q, lseen_d;
  logic                  rseen_q, rseen_d;
  logic [HELD_W-1:0]     lheld_q, lheld_d;
  logic [HELD_W-1:0]     rheld_q, rheld_d;
  logic [COIL_COUNT-1:0] coil_q, coil_d;
  logic                  strobe;

  // Scratch values of the tick path.
  turn_e                 kind;
  logic [DELAY_W-1:0]    base_eff;
  logic [DELAY_W-1:0]    max_eff;
  logic [HELD_W-1:0]     lheld_inc, rheld_inc;
  logic                  ladj, radj;
  logic [TURN_W-1:0]     rem_next;
  logic [DELAY_W-1:0]    dly_a, dly_b;
  logic [DELAY_W:0]      sum_a, sum_b;
  logic [DELAY_W-1:0]    up_a, dn_a, up_b, dn_b;

  assign base_eff = (base_delay_q == '0) ? DELAY_W'(1) : {{(DELAY_W-BASE_W){1'b0}}, base_delay_q};
  assign max_eff  = (max_delay_q == '0) ? DELAY_W'(1) : max_delay_q;
  assign kind     = turn_kind(heading_now, goal_dir);
  assign rem_next = turn_rem_q - TURN_W'(1);

  // Held counts advance on a second boundary for flags already seen.
  assign lheld_inc = (sec_pulse && lseen_q && lheld_q != HELD_MAX) ? lheld_q + HELD_W'(1)
                                                                     : lheld_q;
  assign rheld_inc = (sec_pulse && rseen_q && rheld_q != HELD_MAX) ? rheld_q + HELD_W'(1)
                                                                     : rheld_q;

  assign ladj = left_flag  && (!lseen_q || lheld_inc > hold_seconds_q);
  assign radj = right_flag && (!rseen_q || rheld_inc > hold_seconds_q);

  // The right flag is applied first, then the left flag on the result.
  // On the left wheel right lowers and left raises; on the right wheel the reverse.
  assign sum_a = {1'b0, delay_q} + {{(DELAY_W+1-DSTEP_W){1'b0}}, delay_step_q};
  assign up_a  = (sum_a > {1'b0, max_eff}) ? max_eff : sum_a[DELAY_W-1:0];
  assign dn_a  = (delay_q > {{(DELAY_W-DSTEP_W){1'b0}}, delay_step_q})
                 ? delay_q - {{(DELAY_W-DSTEP_W){1'b0}}, delay_step_q} : DELAY_W'(1);
  assign dly_a = !radj ? delay_q : (wheel_side_q ? dn_a : up_a);

  assign sum_b = {1'b0, dly_a} + {{(DELAY_W+1-DSTEP_W){1'b0}}, delay_step_q};
  assign up_b  = (sum_b > {1'b0, max_eff}) ? max_eff : sum_b[DELAY_W-1:0];
  assign dn_b  = (dly_a > {{(DELAY_W-DSTEP_W){1'b0}}, delay_step_q})
                 ? dly_a - {{(DELAY_W-DSTEP_W){1'b0}}, delay_step_q} : DELAY_W'(1);
  assign dly_b = (!left_flag && !right_flag) ? base_eff
               : (!ladj ? dly_a : (wheel_side_q ? up_b : dn_b));

  always_comb begin
    mode_d     = mode_q;
    phase_d    = phase_q;
    backward_d = backward_q;
    turn_rem_d = turn_rem_q;
    delay_d    = delay_q;
    wait_d     = wait_q;
    lseen_d    = lseen_q;
    rseen_d    = rseen_q;
    lheld_d    = lheld_q;
    rheld_d    = rheld_q;
    coil_d     = coil_q;
    strobe     = 1'b0;

    if (in_acc) begin
      unique case (cmd)
        CMD_START: begin
          delay_d = base_eff;
          wait_d  = '0;
          phase_d = '0;
          lseen_d = 1'b0;
          rseen_d = 1'b0;
          lheld_d = '0;
          rheld_d = '0;
          if (kind != TURN_NONE && turn_steps_q != '0) begin
            mode_d     = MODE_TURN;
            turn_rem_d = turn_steps_q;
            backward_d = (kind == TURN_LEFT) ? wheel_side_q : !wheel_side_q;
          end else begin
            mode_d     = MODE_DRIVE;
            turn_rem_d = '0;
            backward_d = 1'b0;
          end
        end
        CMD_STOP: begin
          mode_d     = MODE_IDLE;
          wait_d     = '0;
          turn_rem_d = '0;
        end
        CMD_TICK: begin
          if (mode_q != MODE_IDLE) begin
            lheld_d = lheld_inc;
            rheld_d = rheld_inc;
            if (wait_q != '0) begin
              wait_d = wait_q - DELAY_W'(1);
            end else if (mode_q == MODE_TURN) begin
              coil_d     = coil_pattern(phase_q);
              strobe     = 1'b1;
              phase_d    = backward_q ? phase_q - PHASE_W'(1) : phase_q + PHASE_W'(1);
              turn_rem_d = rem_next;
              if (rem_next == '0) begin
                mode_d  = MODE_DRIVE;
                phase_d = '0;
              end
              wait_d = delay_q - DELAY_W'(1);
            end else begin
              // Steering flags update their seen bits and held counts per step.
              if (!left_flag) begin
                lseen_d = 1'b0;
                lheld_d = '0;
              end else if (ladj) begin
                lseen_d = 1'b1;
                lheld_d = '0;
              end
              if (!right_flag) begin
                rseen_d = 1'b0;
                rheld_d = '0;
              end else if (radj) begin
                rseen_d = 1'b1;
                rheld_d = '0;
              end
              delay_d = dly_b;
              coil_d  = coil_pattern(phase_q);
              strobe  = 1'b1;
              phase_d = phase_q + PHASE_W'(1);
              wait_d  = dly_b - DELAY_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      phase_q    <= '0;
      backward_q <= 1'b0;
      turn_rem_q <= '0;
      delay_q    <= {{(DELAY_W-BASE_W){1'b0}}, BASE_DELAY_RST};
      wait_q     <= '0;
      lseen_q    <= 1'b0;
      rseen_q    <= 1'b0;
      lheld_q    <= '0;
      rheld_q    <= '0;
      coil_q     <= '0;
    end else begin
      mode_q     <= mode_d;
      phase_q    <= phase_d;
      backward_q <= backward_d;
      turn_rem_q <= turn_rem_d;
      delay_q    <= delay_d;
      wait_q     <= wait_d;
      lseen_q    <= lseen_d;
      rseen_q    <= rseen_d;
      lheld_q    <= lheld_d;
      rheld_q    <= rheld_d;
      coil_q     <= coil_d;
    end
  end

  // ------------------------------------------------------------------------
  // Output register. It refills in the same cycle it is drained.
  // ------------------------------------------------------------------------
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_valid_d   = in_acc ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  assign out_d.coils       = coil_d;
  assign out_d.step_strobe = strobe;
  assign out_d.mode        = mode_d;
  assign out_d.delay_now   = delay_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.delay_now, out_q.mode, out_q.step_strobe, out_q.coils};

  // ------------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------------
  a_strobe_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.step_strobe) |-> (out_q.mode != MODE_IDLE))
    else $error("step strobe reported while idle");

  a_delay_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    delay_q != '0)
    else $error("step delay reached zero");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with an empty output register");

  a_stop_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cmd == CMD_STOP) |=> (out_q.mode == MODE_IDLE && !out_q.step_strobe))
    else $error("stop did not return the drive to idle");

endmodule

[verif/tb_top.sv]
// Self-checking bench for the stepper steering drive core.
//
// Every transfer on the input stream carries one command (millisecond tick, start, stop
// or the unused code) and gives exactly one output transfer. The bench keeps its own
// copy of the drive state and the register settings. It works out the expected output
// at the edge where the input transfer is accepted and queues it. A separate process
// takes output transfers and compares them field by field with the oldest queued entry.
//
// Register writes go through the APB port only while nothing is in flight. The bench
// first drains every pending output, so its register copy never disagrees with the block
// about which items saw which setting.
module tb_top;
  import ssd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned MAX_SHOWN   = 10;

  // The input field allows a fourth command code, and the block must ignore it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Half-step coil sequence, indexed by the phase counter.
  localparam logic [3:0] HALF_STEP [8] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;   // [1:0] command
  // [0] second_pulse, [1] left_flag, [2] right_flag, [5:3] goal_dir, [8:6] heading_now
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [3:0] coils, [4] step_strobe, [6:5] mode, [22:7] delay_now
  logic [23:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  stepper_steering_drive_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Idle rates of the two stream sides, in percent of cycles.
  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 55;

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  // Every item accepted on the input stream, whatever its command.
  int unsigned sent_items = 0;

  result_t pending_outputs [$];
  result_t want_out;
  result_t seen_out;

  // Register copy, starting from the documented reset values.
  logic        cfg_wheel_left = WHEEL_SIDE_RST;
  logic [9:0]  cfg_base       = BASE_DELAY_RST;
  logic [7:0]  cfg_dstep      = DELAY_STEP_RST;
  logic [15:0] cfg_max        = MAX_DELAY_RST;
  logic [3:0]  cfg_hold       = HOLD_SECONDS_RST;
  logic [11:0] cfg_turn_steps = TURN_STEPS_RST;

  // Drive state copy.
  mode_e       drv_mode      = MODE_IDLE;
  logic [2:0]  drv_phase     = '0;
  logic        drv_backward  = 1'b0;
  logic [11:0] drv_turn_left = '0;
  logic [15:0] drv_delay     = 16'(BASE_DELAY_RST);
  logic [15:0] drv_wait      = '0;
  logic        l_seen        = 1'b0;
  logic        r_seen        = 1'b0;
  logic [3:0]  l_held        = '0;
  logic [3:0]  r_held        = '0;
  logic [3:0]  drv_coils     = '0;

  // A zero base delay behaves as one millisecond.
  function automatic logic [15:0] base_or_one();
    return (cfg_base == '0) ? 16'd1 : 16'(cfg_base);
  endfunction

  // Raising saturates at the limit, and a zero limit counts as one.
  function automatic logic [15:0] raised(input logic [15:0] d);
    int unsigned lim;
    int unsigned sum;
    lim = (cfg_max == '0) ? 1 : int'(cfg_max);
    sum = int'(d) + int'(cfg_dstep);
    return (sum > lim) ? 16'(lim) : 16'(sum);
  endfunction

  function automatic logic [15:0] lowered(input logic [15:0] d);
    return (d > 16'(cfg_dstep)) ? d - 16'(cfg_dstep) : 16'd1;
  endfunction

  // Heading pairs are written as octal digits: current heading first, then the goal.
  function automatic turn_e turn_for(input logic [2:0] now, input logic [2:0] goal);
    case ({now, goal})
      6'o13, 6'o24, 6'o32, 6'o41: return TURN_LEFT;
      6'o14, 6'o23, 6'o31, 6'o42: return TURN_RIGHT;
      default: return TURN_NONE;
    endcase
  endfunction

  // A newly raised flag adjusts at once. A flag that stays up adjusts again only after
  // its held seconds pass the hold setting. A dropped flag forgets its history.
  task automatic take_flag(input logic flag, inout logic seen, inout logic [3:0] held,
                           output logic due);
    due = 1'b0;
    if (!flag) begin
      seen = 1'b0;
      held = '0;
    end else if (!seen || held > cfg_hold) begin
      seen = 1'b1;
      held = '0;
      due  = 1'b1;
    end
  endtask

  // Applies one accepted item to the drive state copy and returns the output it causes.
  task automatic advance_drive(input logic [1:0] cmd, input logic sec, input logic lf,
                               input logic rf, input logic [2:0] goal,
                               input logic [2:0] now, output result_t res);
    turn_e kind;
    logic  l_due;
    logic  r_due;
    logic  strobe;
    strobe = 1'b0;
    if (cmd == CMD_START) begin
      kind      = turn_for(now, goal);
      drv_delay = base_or_one();
      drv_wait  = '0;
      drv_phase = '0;
      l_seen    = 1'b0;
      r_seen    = 1'b0;
      l_held    = '0;
      r_held    = '0;
      if (kind != TURN_NONE && cfg_turn_steps != '0) begin
        drv_mode      = MODE_TURN;
        drv_turn_left = cfg_turn_steps;
        // The left wheel backs up for a left turn; the right wheel does the opposite.
        drv_backward  = (kind == TURN_LEFT) ? cfg_wheel_left : !cfg_wheel_left;
      end else begin
        drv_mode      = MODE_DRIVE;
        drv_turn_left = '0;
        drv_backward  = 1'b0;
      end
    end else if (cmd == CMD_STOP) begin
      drv_mode      = MODE_IDLE;
      drv_wait      = '0;
      drv_turn_left = '0;
    end else if (cmd == CMD_TICK && drv_mode != MODE_IDLE) begin
      if (sec) begin
        if (l_seen && l_held != HELD_MAX) l_held = l_held + 4'd1;
        if (r_seen && r_held != HELD_MAX) r_held = r_held + 4'd1;
      end
      if (drv_wait != '0) begin
        drv_wait = drv_wait - 16'd1;
      end else begin
        // Steering only acts before forward drive steps, never during a turn.
        if (drv_mode == MODE_DRIVE) begin
          take_flag(lf, l_seen, l_held, l_due);
          take_flag(rf, r_seen, r_held, r_due);
          if (cfg_wheel_left) begin
            if (r_due) drv_delay = lowered(drv_delay);
            if (l_due) drv_delay = raised(drv_delay);
          end else begin
            if (r_due) drv_delay = raised(drv_delay);
            if (l_due) drv_delay = lowered(drv_delay);
          end
          if (!lf && !rf) drv_delay = base_or_one();
        end
        drv_coils = HALF_STEP[drv_phase];
        strobe    = 1'b1;
        if (drv_mode == MODE_TURN && drv_backward) begin
          drv_phase = drv_phase - 3'd1;
        end else begin
          drv_phase = drv_phase + 3'd1;
        end
        if (drv_mode == MODE_TURN) begin
          drv_turn_left = drv_turn_left - 12'd1;
          if (drv_turn_left == '0) begin
            drv_mode  = MODE_DRIVE;
            drv_phase = '0;
          end
        end
        drv_wait = drv_delay - 16'd1;
      end
    end
    res.coils       = drv_coils;
    res.step_strobe = strobe;
    res.mode        = drv_mode;
    res.delay_now   = drv_delay;
  endtask

  task automatic report_bad(input string what, input result_t want, input result_t got);
    error_count++;
    if (error_count <= MAX_SHOWN) begin
      $write("%s: expected coils %h strobe %0d mode %0d delay %0d, ",
             what, want.coils, want.step_strobe, want.mode, want.delay_now);
      $display("got coils %h strobe %0d mode %0d delay %0d",
               got.coils, got.step_strobe, got.mode, got.delay_now);
    end
  endtask

  // Offers one item, possibly after a random gap, and waits for its transfer. The valid
  // is left high afterwards so back-to-back items never lower and raise it in one step.
  task automatic send_item(input logic [1:0] cmd, input logic sec, input logic lf,
                           input logic rf, input logic [2:0] goal, input logic [2:0] now);
    result_t res;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'd0, now, goal, rf, lf, sec};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items++;
    advance_drive(cmd, sec, lf, rf, goal, now, res);
    pending_outputs.push_back(res);
  endtask

  // Stops offering items and waits until every expected output has arrived.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_outputs.size() != 0);
  endtask

  // One APB write: a setup cycle, an access cycle, then the bus goes idle.
  task automatic write_reg(input reg_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WHEEL_SIDE:   cfg_wheel_left = value[0];
      REG_BASE_DELAY:   cfg_base       = value[9:0];
      REG_DELAY_STEP:   cfg_dstep      = value[7:0];
      REG_MAX_DELAY:    cfg_max        = value[15:0];
      REG_HOLD_SECONDS: cfg_hold       = value[3:0];
      REG_TURN_STEPS:   cfg_turn_steps = value[11:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [2:0] pick_heading();
    return ($urandom_range(99) < 85) ? 3'($urandom_range(4, 1)) : 3'($urandom_range(7));
  endfunction

  // Writes all six registers. Most settings keep delays short so steps come often, and
  // the extremes of each register turn up regularly.
  task automatic random_config();
    logic [31:0] base;
    logic [31:0] dstep;
    logic [31:0] lim;
    logic [31:0] turn;
    case ($urandom_range(9))
      0:       base = 0;
      1:       base = 1023;
      2:       base = $urandom_range(1023);
      default: base = $urandom_range(4, 1);
    endcase
    case ($urandom_range(9))
      0:       dstep = 0;
      1:       dstep = 255;
      2:       dstep = $urandom_range(255);
      default: dstep = $urandom_range(6, 1);
    endcase
    case ($urandom_range(9))
      0:       lim = 0;
      1:       lim = 65535;
      2:       lim = $urandom_range(65535);
      3:       lim = 1;
      default: lim = $urandom_range(40, 2);
    endcase
    case ($urandom_range(9))
      0:       turn = 0;
      1:       turn = 4095;
      default: turn = $urandom_range(10, 1);
    endcase
    write_reg(REG_WHEEL_SIDE, $urandom_range(1));
    write_reg(REG_BASE_DELAY, base);
    write_reg(REG_DELAY_STEP, dstep);
    write_reg(REG_MAX_DELAY, lim);
    write_reg(REG_HOLD_SECONDS, ($urandom_range(9) < 7) ? $urandom_range(3) : $urandom_range(15));
    write_reg(REG_TURN_STEPS, turn);
  endtask

  // One trip: a start, a stretch of ticks with steering flags that persist for a while,
  // a little noise along the way, and usually a stop at the end.
  task automatic drive_run();
    int unsigned n_ticks;
    int unsigned roll;
    logic        lf;
    logic        rf;
    if ($urandom_range(9) == 0) begin
      send_item(2'($urandom_range(3)), 1'($urandom), 1'($urandom), 1'($urandom),
                3'($urandom_range(7)), 3'($urandom_range(7)));
    end
    send_item(CMD_START, 1'($urandom), 1'($urandom), 1'($urandom), pick_heading(),
              pick_heading());
    n_ticks = $urandom_range(70, 10);
    lf = 1'($urandom);
    rf = 1'($urandom);
    for (int unsigned i = 0; i < n_ticks; i++) begin
      if ($urandom_range(99) < 6) lf = !lf;
      if ($urandom_range(99) < 6) rf = !rf;
      roll = $urandom_range(99);
      if (roll < 2) begin
        send_item(CMD_UNUSED, 1'($urandom), lf, rf, 3'($urandom_range(7)),
                  3'($urandom_range(7)));
      end else if (roll < 4) begin
        send_item(CMD_START, 1'($urandom), lf, rf, pick_heading(), pick_heading());
      end else if (roll < 5) begin
        send_item(CMD_STOP, 1'($urandom), lf, rf, 3'($urandom_range(7)),
                  3'($urandom_range(7)));
      end else begin
        send_item(CMD_TICK, 1'($urandom_range(99) < 30), lf, rf, 3'($urandom_range(7)),
                  3'($urandom_range(7)));
      end
      // Now and then the sender holds off until the block has answered everything.
      if (roll == 99 && $urandom_range(3) == 0) wait_drained();
    end
    if ($urandom_range(99) < 85) begin
      send_item(CMD_STOP, 1'($urandom), 1'($urandom), 1'($urandom), 3'($urandom_range(7)),
                3'($urandom_range(7)));
    end
  endtask

  // Out of reset: a tick, a stop and the unused code must all leave the drive idle.
  task automatic test_idle_inputs();
    send_item(CMD_TICK, 1'b1, 1'b1, 1'b1, 3'd7, 3'd7);
    send_item(CMD_STOP, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0);
    send_item(CMD_UNUSED, 1'b1, 1'b0, 1'b1, 3'd5, 3'd2);
  endtask

  // Left and right turns on the left wheel, a turn that runs into forward drive, and
  // starts with equal or out-of-range headings that skip the turn.
  task automatic test_turn_choice();
    wait_drained();
    write_reg(REG_TURN_STEPS, 2);
    write_reg(REG_BASE_DELAY, 1);
    send_item(CMD_START, 1'b0, 1'b0, 1'b0, 3'd3, 3'd1);
    repeat (3) send_item(CMD_TICK, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0);
    send_item(CMD_START, 1'b0, 1'b0, 1'b0, 3'd2, 3'd4);
    repeat (2) send_item(CMD_TICK, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0);
    send_item(CMD_START, 1'b0, 1'b0, 1'b0, 3'd2, 3'd2);
    send_item(CMD_TICK, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0);
    send_item(CMD_START, 1'b0, 1'b0, 1'b0, 3'd0, 3'd7);
    send_item(CMD_TICK, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0);
    send_item(CMD_STOP, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0);
  endtask

  // Right wheel with a zero base delay, a zero limit and a zero turn length, so the
  // start drives forward at once and every adjustment runs into the delay bounds.
  task automatic test_steering_limits();
    wait_drained();
    write_reg(REG_WHEEL_SIDE, 0);
    write_reg(REG_BASE_DELAY, 0);
    write_reg(REG_DELAY_STEP, 255);
    write_reg(REG_MAX_DELAY, 0);
    write_reg(REG_HOLD_SECONDS, 15);
    write_reg(REG_TURN_STEPS, 0);
    send_item(CMD_START, 1'b0, 1'b0, 1'b0, 3'd3, 3'd1);
    send_item(CMD_TICK, 1'b1, 1'b1, 1'b0, 3'd0, 3'd0);
    send_item(CMD_TICK, 1'b1, 1'b1, 1'b1, 3'd0, 3'd0);
    send_item(CMD_TICK, 1'b0, 1'b0, 1'b1, 3'd0, 3'd0);
    send_item(CMD_TICK, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0);
  endtask

  // The other extreme of every register: the longest turn at the longest base delay.
  task automatic test_register_extremes();
    wait_drained();
    write_reg(REG_WHEEL_SIDE, 1);
    write_reg(REG_BASE_DELAY, 1023);
    write_reg(REG_DELAY_STEP, 0);
    write_reg(REG_MAX_DELAY, 65535);
    write_reg(REG_HOLD_SECONDS, 0);
    write_reg(REG_TURN_STEPS, 4095);
    send_item(CMD_START, 1'b0, 1'b0, 1'b0, 3'd4, 3'd1);
    repeat (2) send_item(CMD_TICK, 1'b1, 1'b1, 1'b1, 3'd0, 3'd0);
    send_item(CMD_STOP, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0);
  endtask

  // Random trips under one pair of idle rates, with new register settings every few trips.
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned n_items);
    int unsigned first;
    int unsigned trips;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first = sent_items;
    trips = 0;
    while (sent_items - first < n_items) begin
      if (trips % 3 == 0) begin
        wait_drained();
        random_config();
      end
      drive_run();
      trips++;
    end
  endtask

  // Output side: check every transfer, then pick the ready for the next edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_out = result_t'(m_axis_tdata[22:0]);
      if (pending_outputs.size() == 0) begin
        report_bad("output with nothing pending", '0, seen_out);
      end else begin
        want_out = pending_outputs.pop_front();
        if (want_out.coils !== seen_out.coils || want_out.step_strobe !== seen_out.step_strobe ||
            want_out.mode !== seen_out.mode || want_out.delay_now !== seen_out.delay_now) begin
          report_bad("mismatch", want_out, seen_out);
        end
      end
    end
    m_axis_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_idle_inputs();
    test_turn_choice();
    test_steering_limits();
    test_register_extremes();
    test_random_traffic(28, 55, 520);
    test_random_traffic(55, 28, 520);
    test_random_traffic(0, 0, 490);
    wait_drained();
    // Give the block time to show any output it should not produce.
    repeat (8) @(posedge clk_i);
    if (error_count == 0 && pending_outputs.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ssd_pkg.sv
rtl/stepper_steering_drive_core.sv
verif/tb_top.sv
